>>> hw/rtl/ordered_list_engine_assert.svh
// Assertion macros of the ordered list engine, used by the datapath.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/ole_pkg.sv
// Shared types and constants of the ordered list engine.
package ole_pkg;

	localparam int DATA_W     = 32;
	localparam int ACT_W      = 3;
	localparam int POS_W      = 8;
	localparam int STS_W      = 2;
	localparam int OUT_CNT_W  = 5;
	localparam int DUMP_LIMIT = 16;

	typedef enum logic [ACT_W-1:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_ORD   = 3'd1,
		ACT_DEL_AT    = 3'd2,
		ACT_DEL_LEFT  = 3'd3,
		ACT_DEL_RIGHT = 3'd4,
		ACT_DUMP      = 3'd5
	} action_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_INVALID = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic scan;
		logic apply;
		logic dump_step;
		logic wrap_step;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dump_go;
		logic out_last;
		logic wrap_done;
	} sts_t;

endpackage

>>> hw/rtl/ole_if.sv
// Request and response channel interfaces of the ordered list engine.
interface ole_req_if import ole_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, action, value, position, input ready);
	modport sink (input valid, action, value, position, output ready);
endinterface

interface ole_rsp_if import ole_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [STS_W-1:0]         status;
	logic signed [DATA_W-1:0] data;
	logic [OUT_CNT_W-1:0]     count;
	logic                     last;

	modport source (output valid, status, data, count, last, input ready);
	modport sink (input valid, status, data, count, last, output ready);
endinterface

>>> hw/rtl/ordered_list_engine.sv
// Top level of the ordered list engine: a list of signed words kept in entry cells.
//
// One request channel (req) carries action, value and position; one response
// channel (rsp) carries status, data, count and last. Both use valid/ready and
// move a word at each edge where both are high.
// A request is taken only while the engine is idle. It is captured, compared
// against every entry at once in the scan state, then applied, and the first
// response comes from the result register; no new request is taken before the
// last response has been taken. All entries shift in parallel.
// A dump streams one entry per cycle while the receiver holds ready high,
// taken from cell zero while the cells rotate, and ends with last set; an
// empty list gives one response. After the final streamed entry the row
// finishes its rotation, once more per entry beyond the stream limit, before
// the next request is taken.
// While the receiver holds ready low the response stays in its register and
// no new request is accepted. Reset empties the list at once; entry contents
// are not cleared and no clearing pass is needed.
module ordered_list_engine import ole_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input logic       clk,
	input logic       arst_n,
	ole_req_if.sink   req,
	ole_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	ole_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Entry cells and result register.
	ole_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_action   (req.action),
		.in_value    (req.value),
		.in_position (req.position),
		.out_status  (rsp.status),
		.out_data    (rsp.data),
		.out_count   (rsp.count),
		.out_last    (rsp.last)
	);

endmodule

>>> hw/rtl/ole_datapath.sv
// Datapath of the ordered list engine: entry cells, compare row and result register.
`include "ordered_list_engine_assert.svh"

module ole_datapath import ole_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic [ACT_W-1:0]         in_action,
	input  logic signed [DATA_W-1:0] in_value,
	input  logic [POS_W-1:0]         in_position,
	output logic [STS_W-1:0]         out_status,
	output logic signed [DATA_W-1:0] out_data,
	output logic [OUT_CNT_W-1:0]     out_count,
	output logic                     out_last
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	action_t                  act_q;
	logic signed [DATA_W-1:0] val_q;
	logic [POS_W-1:0]         pos_q;
	logic [CAPACITY-1:0]      lt_q;
	logic signed [DATA_W-1:0] ent_q [CAPACITY];
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         rot_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] data_q;
	logic                     last_q;

	logic                     is_ins;
	logic                     is_del;
	logic                     full;
	logic                     empty;
	logic [IDX_W-1:0]         ord_idx;
	logic [IDX_W-1:0]         ins_idx;
	logic [POS_W:0]           pos_x;
	logic [POS_W:0]           n_x;
	logic [POS_W:0]           del_pos;
	logic                     del_ok;
	logic [IDX_W-1:0]         del_idx;
	logic signed [DATA_W-1:0] del_val;
	logic [CNT_W-1:0]         lim;
	logic                     ins_we;
	logic                     del_we;
	logic                     rot_we;
	logic                     dump_start;

	// Request decode.
	assign is_ins = (act_q == ACT_INS_FRONT) || (act_q == ACT_INS_ORD);
	assign is_del = (act_q == ACT_DEL_AT) || (act_q == ACT_DEL_LEFT) || (act_q == ACT_DEL_RIGHT);
	assign full   = (cnt_q == CNT_W'(CAPACITY));
	assign empty  = (cnt_q == '0);

	// First cell that is not smaller than the new value; cells past the count never are.
	always_comb begin
		ord_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!lt_q[i]) begin
				ord_idx = IDX_W'(i);
			end
		end
	end

	assign ins_idx = (act_q == ACT_INS_ORD) ? ord_idx : '0;

	// Position check and removal index for the three delete flavors.
	assign pos_x = {1'b0, pos_q};
	assign n_x   = (POS_W + 1)'(cnt_q);

	always_comb begin
		del_ok  = 1'b0;
		del_pos = '0;
		unique case (act_q)
			ACT_DEL_AT: begin
				del_ok  = (pos_x != '0) && (pos_x <= n_x);
				del_pos = pos_x - (POS_W + 1)'(1);
			end
			ACT_DEL_LEFT: begin
				del_ok  = (pos_x > (POS_W + 1)'(1)) && (pos_x <= n_x);
				del_pos = pos_x - (POS_W + 1)'(2);
			end
			ACT_DEL_RIGHT: begin
				del_ok  = (pos_x != '0) && (pos_x < n_x);
				del_pos = pos_x;
			end
			default: begin
				del_ok  = 1'b0;
				del_pos = '0;
			end
		endcase
	end

	assign del_idx = IDX_W'(del_pos);

	// Each cell offers its word when it is the one being removed.
	always_comb begin
		del_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (IDX_W'(i) == del_idx) begin
				del_val = ent_q[i];
			end
		end
	end

	// Number of entries a dump streams.
	always_comb begin
		if (32'(cnt_q) > DUMP_LIMIT) begin
			lim = CNT_W'(DUMP_LIMIT);
		end else begin
			lim = cnt_q;
		end
	end

	assign dump_start = cmd.apply && (act_q == ACT_DUMP) && !empty;
	assign ins_we     = cmd.apply && is_ins && !full;
	assign del_we     = cmd.apply && is_del && !empty && del_ok;
	assign rot_we     = dump_start || cmd.dump_step || cmd.wrap_step;

	// Request capture and the compare row.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action_t'(in_action);
			val_q <= in_value;
			pos_q <= in_position;
		end
		if (cmd.scan) begin
			for (int i = 0; i < CAPACITY; i++) begin
				lt_q[i] <= (CNT_W'(i) < cnt_q) && (ent_q[i] < val_q);
			end
		end
	end

	// Entry cells: shift right on insert, shift left on delete, rotate during a dump.
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (ins_we) begin
				if (IDX_W'(i) == ins_idx) begin
					ent_q[i] <= val_q;
				end else if (IDX_W'(i) > ins_idx) begin
					ent_q[i] <= ent_q[(i == 0) ? 0 : i - 1];
				end
			end else if (del_we) begin
				if ((IDX_W'(i) >= del_idx) && (i < CAPACITY - 1)) begin
					ent_q[i] <= ent_q[(i == CAPACITY - 1) ? i : i + 1];
				end
			end else if (rot_we) begin
				if (CNT_W'(i + 1) == cnt_q) begin
					ent_q[i] <= ent_q[0];
				end else if (CNT_W'(i + 1) < cnt_q) begin
					ent_q[i] <= ent_q[(i == CAPACITY - 1) ? i : i + 1];
				end
			end
		end
	end

	// Entry count and dump rotation count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rot_q <= '0;
		end else begin
			if (ins_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (del_we) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (dump_start) begin
				rot_q <= CNT_W'(1);
			end else if (cmd.dump_step || cmd.wrap_step) begin
				rot_q <= rot_q + CNT_W'(1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			last_q <= 1'b1;
			data_q <= '0;
			unique case (act_q)
				ACT_INS_FRONT, ACT_INS_ORD: begin
					status_q <= full ? ST_FULL : ST_OK;
				end
				ACT_DEL_AT, ACT_DEL_LEFT, ACT_DEL_RIGHT: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else if (del_ok) begin
						status_q <= ST_OK;
						data_q   <= del_val;
					end else begin
						status_q <= ST_INVALID;
					end
				end
				ACT_DUMP: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						status_q <= ST_OK;
						data_q   <= ent_q[0];
						last_q   <= (lim == CNT_W'(1));
					end
				end
				default: begin
					status_q <= ST_INVALID;
				end
			endcase
		end else if (cmd.dump_step) begin
			status_q <= ST_OK;
			data_q   <= ent_q[0];
			last_q   <= (32'(rot_q) + 1 == 32'(lim));
		end
	end

	assign out_status = status_q;
	assign out_data   = data_q;
	assign out_count  = OUT_CNT_W'(cnt_q);
	assign out_last   = last_q;

	assign sts.dump_go   = (act_q == ACT_DUMP) && !empty;
	assign sts.out_last  = last_q;
	assign sts.wrap_done = (rot_q == cnt_q);

	// A successful insert reports ok and grows the list by one.
	`OLE_ASSERT_NEXT(a_ins_grow, ins_we,
		(status_q == ST_OK) && (cnt_q == $past(cnt_q) + 1), "insert did not grow the list")

	// A delete that reports ok shrinks the list by one.
	`OLE_ASSERT_NEXT(a_del_shrink, cmd.apply && is_del,
		(status_q != ST_OK) || (cnt_q == $past(cnt_q) - 1), "delete did not shrink the list")

	// Streaming and rewinding a dump leave the count alone.
	`OLE_ASSERT_NEXT(a_dump_count, cmd.dump_step || cmd.wrap_step, $stable(cnt_q),
		"dump changed the count")

	// Rotation never runs past the number of entries.
	`OLE_ASSERT_SAME(a_rot_bound, cmd.dump_step || cmd.wrap_step, rot_q < cnt_q,
		"dump rotated too far")

endmodule

>>> hw/rtl/ole_ctrl.sv
// Controller state machine of the ordered list engine.
module ole_ctrl import ole_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_APPLY = 6'b000100,
		S_RESP  = 6'b001000,
		S_DUMP  = 6'b010000,
		S_WRAP  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				state_d = S_APPLY;
			end
			S_APPLY: begin
				state_d = sts.dump_go ? S_DUMP : S_RESP;
			end
			S_RESP: begin
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			S_DUMP: begin
				if (rsp_ready && sts.out_last) begin
					state_d = S_WRAP;
				end
			end
			S_WRAP: begin
				if (sts.wrap_done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Handshakes and datapath commands.
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP) || (state_q == S_DUMP);

	assign cmd.capture   = (state_q == S_IDLE) && req_valid;
	assign cmd.scan      = (state_q == S_SCAN);
	assign cmd.apply     = (state_q == S_APPLY);
	assign cmd.dump_step = (state_q == S_DUMP) && rsp_ready && !sts.out_last;
	assign cmd.wrap_step = (state_q == S_WRAP) && !sts.wrap_done;

endmodule
